// ===== rtl/core/sprt_bisection_search_assert.svh =====
// Assertion macros for the SPRT bisection search block
`ifndef SPRT_BISECTION_SEARCH_ASSERT_SVH
`define SPRT_BISECTION_SEARCH_ASSERT_SVH

// check cons in the same cycle as ante
`define SBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define SBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sbs_pkg.sv =====
// Package: types, constants and register map of the SPRT bisection search block
`timescale 1ns / 1ps
package sbs_pkg;

   localparam int SBS_MAX_PATH_DEF = 16;

   localparam int RTT_W     = 16;
   localparam int LEN_CFG_W = 5;
   localparam int THR_U_W   = 31;
   localparam int LLR_W     = 32;
   localparam int CNT_W     = 16;
   localparam int OUT_IDX_W = 4;
   localparam int VERD_W    = 2;

   localparam int DIV_W     = 28;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int XMAG_W    = RTT_W + 1;

   localparam logic [RTT_W-1:0] BASE_DEFAULT = RTT_W'(40);
   localparam logic [10:0]      LLR_SCALE    = 11'd2000;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [1:0] {
      REG_BASELINE  = 2'd0,
      REG_THR_UPPER = 2'd1,
      REG_THR_LOWER = 2'd2,
      REG_PATH_LEN  = 2'd3
   } sbs_reg_type;

   typedef enum logic [1:0] {
      VERD_PROBE     = 2'd0,
      VERD_NORMAL    = 2'd1,
      VERD_ANOMALOUS = 2'd2
   } sbs_verdict_type;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } sbs_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_UPDATE
   } sbs_state_type;

   typedef struct packed {
      logic [RTT_W-1:0]     baseline;
      logic [THR_U_W-1:0]   thr_upper;
      logic [LLR_W-1:0]     thr_lower;
      logic [LEN_CFG_W-1:0] path_len;
   } sbs_cfg_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic step;
      logic commit;
   } sbs_cmd_type;

   typedef struct packed {
      logic live_sample;
   } sbs_sts_type;

endpackage

// ===== rtl/core/sprt_bisection_search.sv =====
// Top level of the SPRT-driven bisection search block
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser opcode, tdata rtt_sample
//   rsp      out  rsp_tvalid/rsp_tready  tdata result fields
//   csr      in   APB write/read         four registers at 4*i
//
// A sample word passes through capture, scaling, a 28-step restoring divider
// by the baseline, and commit. A start word, or a sample after the search has
// finished, goes from capture straight to commit.
// Reset is synchronous; search, control and CSR state take reset values, data registers do not.
// The next word is accepted while a result waits; a stalled rsp holds the
// commit stage, and no word is accepted until that result moves.
`timescale 1ns / 1ps
module sprt_bisection_search
   import sbs_pkg::*;
#(
   parameter int MAX_PATH = SBS_MAX_PATH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [RTT_W-1:0]      req_tdata,   // [15:0] rtt_sample
   input  logic                  req_tuser,   // [0] opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] verdict, [2] search_done, [6:3] suspect_index, [7] suspect_valid,
   // [11:8] probe_index, [12] probe_valid, [44:13] llr_sum,
   // [60:45] probes_taken, [63:61] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   sbs_cfg_type cfg;
   sbs_cmd_type cmd;
   sbs_sts_type sts;

   sbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sbs_datapath #(
      .MAX_PATH (MAX_PATH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/core/sbs_csr.sv =====
// Configuration registers behind the APB-style port
`timescale 1ns / 1ps
module sbs_csr
   import sbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output sbs_cfg_type           cfg
);

   sbs_cfg_type cfg_ff, cfg_in;
   sbs_reg_type reg_sel;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = sbs_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_BASELINE:  cfg_in.baseline  = csr_pwdata[RTT_W-1:0];
            REG_THR_UPPER: cfg_in.thr_upper = csr_pwdata[THR_U_W-1:0];
            REG_THR_LOWER: cfg_in.thr_lower = csr_pwdata[LLR_W-1:0];
            REG_PATH_LEN:  cfg_in.path_len  = csr_pwdata[LEN_CFG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_BASELINE:  csr_prdata = CSR_DATA_W'(cfg_ff.baseline);
         REG_THR_UPPER: csr_prdata = CSR_DATA_W'(cfg_ff.thr_upper);
         REG_THR_LOWER: csr_prdata = cfg_ff.thr_lower;
         REG_PATH_LEN:  csr_prdata = CSR_DATA_W'(cfg_ff.path_len);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baseline  <= BASE_DEFAULT;
         cfg_ff.thr_upper <= THR_U_W'(2944);
         cfg_ff.thr_lower <= -LLR_W'(2944);
         cfg_ff.path_len  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/sbs_ctrl.sv =====
// Controller: sequences capture, scaling, serial division and commit of one word
`timescale 1ns / 1ps
module sbs_ctrl
   import sbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  sbs_sts_type sts,
   output sbs_cmd_type cmd
);

   sbs_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign slot_free  = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = sts.live_sample ? ST_PREP : ST_UPDATE;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            step_in  = DIV_CNT_W'(DIV_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_UPDATE: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/sbs_datapath.sv =====
// Datapath: search state, LLR scaling, serial divider and result register
`timescale 1ns / 1ps
module sbs_datapath
   import sbs_pkg::*;
#(
   parameter int MAX_PATH = SBS_MAX_PATH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tuser,
   input  logic [RTT_W-1:0]      req_tdata,
   input  sbs_cfg_type           cfg,
   input  sbs_cmd_type           cmd,
   output sbs_sts_type           sts,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_PATH);
   localparam int LEN_W = IDX_W + 1;

   logic [IDX_W-1:0] low_ff, low_in, high_ff, high_in, mid_ff, mid_in, sus_ff, sus_in;
   logic [LLR_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fin_ff, fin_in;

   logic             op_ff;
   logic [RTT_W-1:0] rtt_ff;
   logic             neg_ff;
   logic [RTT_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic [RTT_W-1:0]  base_eff;
   logic [LEN_W-1:0]  n_len;
   logic [XMAG_W:0]   x_val;
   logic [XMAG_W-1:0] x_mag;
   logic [DIV_W-1:0]  prod;
   logic [RTT_W:0]    rem_sh;
   logic [RTT_W:0]    rem_try;
   logic              fits;

   logic [LLR_W:0]    d_ext, sum_ext;
   logic [LLR_W-1:0]  acc_sat;
   logic              hit_up, hit_lo;
   logic [LEN_W-1:0]  mid_sum;
   logic [VERD_W-1:0] verdict;
   logic [IDX_W-1:0]  probe;
   logic              probe_ok, sus_ok;
   logic [RSP_DATA_W-1:0] rsp_in;

   assign base_eff = (cfg.baseline == '0) ? BASE_DEFAULT : cfg.baseline;
   assign n_len    = (32'(cfg.path_len) > MAX_PATH) ? LEN_W'(MAX_PATH)
                                                    : LEN_W'(32'(cfg.path_len));
   assign sts.live_sample = (req_tuser == OP_SAMPLE) & ~fin_ff;

   assign x_val = {2'b00, rtt_ff} - {1'b0, base_eff, 1'b0};
   assign x_mag = x_val[XMAG_W] ? XMAG_W'(-x_val) : x_val[XMAG_W-1:0];
   assign prod  = DIV_W'(x_mag) * DIV_W'(LLR_SCALE);

   assign rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
   assign rem_try = rem_sh - {1'b0, base_eff};
   assign fits    = (rem_sh >= {1'b0, base_eff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser;
         rtt_ff <= req_tdata;
      end
      if (cmd.prep) begin
         neg_ff <= x_val[XMAG_W];
         rem_ff <= '0;
         quo_ff <= prod;
      end else if (cmd.step) begin
         rem_ff <= fits ? rem_try[RTT_W-1:0] : rem_sh[RTT_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      d_ext   = neg_ff ? -(LLR_W+1)'(quo_ff) : (LLR_W+1)'(quo_ff);
      sum_ext = {acc_ff[LLR_W-1], acc_ff} + d_ext;
      if (sum_ext[LLR_W] != sum_ext[LLR_W-1]) begin
         acc_sat = sum_ext[LLR_W] ? {1'b1, {(LLR_W-1){1'b0}}} : {1'b0, {(LLR_W-1){1'b1}}};
      end else begin
         acc_sat = sum_ext[LLR_W-1:0];
      end
      hit_up = $signed({acc_sat[LLR_W-1], acc_sat}) >= $signed({2'b00, cfg.thr_upper});
      hit_lo = $signed(acc_sat) <= $signed(cfg.thr_lower);

      low_in  = low_ff;
      high_in = high_ff;
      mid_in  = mid_ff;
      sus_in  = sus_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      fin_in  = fin_ff;
      verdict = VERD_PROBE;
      mid_sum = '0;

      if (op_ff == OP_START) begin
         low_in  = '0;
         high_in = (n_len != '0) ? IDX_W'(n_len - 1'b1) : '0;
         mid_in  = high_in >> 1;
         acc_in  = '0;
         cnt_in  = '0;
         fin_in  = 1'b0;
      end else if (fin_ff) begin
         verdict = VERD_ANOMALOUS;
      end else begin
         acc_in = acc_sat;
         cnt_in = cnt_ff + 1'b1;
         if (hit_up || hit_lo) begin
            acc_in = '0;
            cnt_in = '0;
            if (hit_up) begin
               verdict = VERD_ANOMALOUS;
               high_in = mid_ff;
            end else begin
               verdict = VERD_NORMAL;
               low_in  = mid_ff;
            end
            mid_sum = {1'b0, low_in} + {1'b0, high_in};
            if ({1'b0, high_in} <= {1'b0, low_in} + 1'b1) begin
               fin_in = 1'b1;
               sus_in = hit_up ? low_in : high_in;
            end else begin
               mid_in = IDX_W'(mid_sum >> 1);
            end
         end
      end

      probe    = '0;
      probe_ok = 1'b0;
      if ({1'b0, mid_in} + 1'b1 >= n_len) begin
         if (n_len != '0) begin
            probe    = (mid_in != '0) ? mid_in - 1'b1 : '0;
            probe_ok = 1'b1;
         end
      end else begin
         probe    = mid_in + 1'b1;
         probe_ok = 1'b1;
      end
      sus_ok = fin_in & ({1'b0, sus_in} < n_len);

      rsp_in = RSP_DATA_W'({cnt_in, acc_in, probe_ok, OUT_IDX_W'(32'(probe)), sus_ok,
                            (fin_in ? OUT_IDX_W'(32'(sus_in)) : OUT_IDX_W'(0)),
                            fin_in, verdict});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '0;
         mid_ff  <= '0;
         sus_ff  <= '0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         fin_ff  <= 1'b0;
      end else if (cmd.commit) begin
         low_ff  <= low_in;
         high_ff <= high_in;
         mid_ff  <= mid_in;
         sus_ff  <= sus_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         fin_ff  <= fin_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ===== rtl/core/sbs_checker.sv =====
// Port-level checker for the SPRT bisection search block, with its bind
`timescale 1ns / 1ps
`include "sprt_bisection_search_assert.svh"
module sbs_checker
   import sbs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `SBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "rsp word changed while stalled")
   `SBS_ASSERT_NOW(a_verdict_code, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'b11, "verdict code out of range")
   `SBS_ASSERT_NOW(a_no_suspect, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[7:3] == 5'd0, "suspect shown before search done")
   `SBS_ASSERT_NOW(a_decision_clear, clock, reset, rsp_tvalid && rsp_tdata[1:0] != 2'b00, rsp_tdata[60:13] == 48'd0, "sum or count not cleared on decision")

endmodule

bind sprt_bisection_search sbs_checker u_sbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb.sv =====
// Testbench for the SPRT bisection search block: register setup, stream traffic, result check
`timescale 1ns / 1ps
module tb;
   import sbs_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 125;
   localparam int MAX_STEPS    = 100;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AT_WORD = 450;
   localparam int DRAIN_CYCLES = 40;
   localparam longint LLR_MAX  = 64'sd2147483647;
   localparam longint LLR_MIN  = -64'sd2147483648;

   typedef struct packed {
      logic [2:0]      pad;
      logic [15:0]     probes;
      logic [31:0]     llr;
      logic            probe_ok;
      logic [3:0]      probe;
      logic            suspect_ok;
      logic [3:0]      suspect;
      logic            done;
      sbs_verdict_type verdict;
   } search_result_type;

   class bisection_scoreboard;
      bit [15:0]         baseline;
      bit [30:0]         thr_upper;
      bit signed [31:0]  thr_lower;
      bit [4:0]          path_len;
      int unsigned       low_b, high_b, mid, suspect;
      bit signed [31:0]  llr;
      bit [15:0]         probes;
      bit                done;
      search_result_type pending_results[$];
      int                fails, checked;

      function new();
         baseline  = BASE_DEFAULT;
         thr_upper = 31'd2944;
         thr_lower = -32'sd2944;
         path_len  = '0;
         low_b     = 0;
         high_b    = 0;
         mid       = 0;
         suspect   = 0;
         llr       = '0;
         probes    = '0;
         done      = 1'b0;
         fails     = 0;
         checked   = 0;
      endfunction

      function void write_reg(sbs_reg_type r, logic [31:0] v);
         case (r)
            REG_BASELINE:  baseline  = v[15:0];
            REG_THR_UPPER: thr_upper = v[30:0];
            REG_THR_LOWER: thr_lower = v;
            REG_PATH_LEN:  path_len  = v[4:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(sbs_reg_type r);
         case (r)
            REG_BASELINE:  return {16'd0, baseline};
            REG_THR_UPPER: return {1'b0, thr_upper};
            REG_THR_LOWER: return thr_lower;
            REG_PATH_LEN:  return {27'd0, path_len};
            default:       return '0;
         endcase
      endfunction

      function int unsigned eff_baseline();
         return (baseline != 0) ? baseline : BASE_DEFAULT;
      endfunction

      function sbs_verdict_type take_sample(logic [RTT_W-1:0] rtt);
         longint b, x, d, s;
         if (done) return VERD_ANOMALOUS;
         b = eff_baseline();
         x = longint'(rtt) - 2 * b;
         d = (2000 * x) / b;
         s = longint'(llr) + d;
         if (s > LLR_MAX) s = LLR_MAX;
         if (s < LLR_MIN) s = LLR_MIN;
         llr = s[31:0];
         probes++;
         if (longint'(llr) >= longint'(thr_upper)) begin
            high_b = mid;
            llr    = '0;
            probes = '0;
            if (high_b <= low_b + 1) begin
               done    = 1'b1;
               suspect = low_b;
            end else begin
               mid = (low_b + high_b) / 2;
            end
            return VERD_ANOMALOUS;
         end
         if (llr <= thr_lower) begin
            low_b  = mid;
            llr    = '0;
            probes = '0;
            if (high_b <= low_b + 1) begin
               done    = 1'b1;
               suspect = high_b;
            end else begin
               mid = (low_b + high_b) / 2;
            end
            return VERD_NORMAL;
         end
         return VERD_PROBE;
      endfunction

      function void add_word(sbs_op_type op, logic [RTT_W-1:0] rtt);
         int unsigned       n;
         search_result_type r;
         n = (path_len > SBS_MAX_PATH_DEF) ? SBS_MAX_PATH_DEF : path_len;
         r = '0;
         r.verdict = VERD_PROBE;
         if (op == OP_START) begin
            low_b  = 0;
            high_b = (n > 0) ? n - 1 : 0;
            mid    = (low_b + high_b) / 2;
            llr    = '0;
            done   = 1'b0;
            probes = '0;
         end else begin
            r.verdict = take_sample(rtt);
         end
         if (mid + 1 >= n) begin
            if (n > 0) begin
               r.probe    = (mid > 0) ? 4'(mid - 1) : 4'd0;
               r.probe_ok = 1'b1;
            end
         end else begin
            r.probe    = 4'(mid + 1);
            r.probe_ok = 1'b1;
         end
         r.done       = done;
         r.suspect    = done ? 4'(suspect) : 4'd0;
         r.suspect_ok = done && (suspect < n);
         r.llr        = llr;
         r.probes     = probes;
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         fails++;
         if (fails <= 40) $display("MISMATCH %s", msg);
      endtask

      task cmp_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("word %0d %s: got %0h, want %0h", checked, name, got, want));
      endtask

      task check_word(logic [RSP_DATA_W-1:0] data);
         search_result_type got, want;
         got = search_result_type'(data);
         if (pending_results.size() == 0) begin
            report($sformatf("word %0d: result with nothing pending", checked));
         end else begin
            want = pending_results.pop_front();
            cmp_field("verdict", got.verdict, want.verdict);
            cmp_field("search_done", got.done, want.done);
            cmp_field("suspect_index", got.suspect, want.suspect);
            cmp_field("suspect_valid", got.suspect_ok, want.suspect_ok);
            cmp_field("probe_index", got.probe, want.probe);
            cmp_field("probe_valid", got.probe_ok, want.probe_ok);
            cmp_field("llr_sum", got.llr, want.llr);
            cmp_field("probes_taken", got.probes, want.probes);
            cmp_field("pad", got.pad, want.pad);
         end
         checked++;
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RTT_W-1:0]      req_tdata   = '0;    // [15:0] rtt_sample
   logic                  req_tuser   = 1'b0;  // [0] opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [1:0] verdict, [2] search_done, [6:3] suspect_index, [7] suspect_valid,
   // [11:8] probe_index, [12] probe_valid, [44:13] llr_sum,
   // [60:45] probes_taken, [63:61] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bisection_scoreboard sb;
   int                  burst_left = 0;
   int                  words_sent = 0;
   logic                holding    = 1'b0;
   logic [11:0]         stall_pat  = 12'hFFF;
   int                  pat_age    = 0;
   bit                  stall_on   = 1'b0;

   sprt_bisection_search uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_word(rsp_tdata);
         if (pat_age == 0) begin
            stall_on  = ($urandom_range(0, 3) != 0);
            stall_pat = 12'($urandom) | 12'h1;
            pat_age   = 300;
         end else begin
            pat_age--;
         end
         stall_pat = {stall_pat[10:0], stall_pat[11]};
         rsp_tready <= !holding && (!stall_on || stall_pat[0]);
      end
   end

   // hold off the result side mid-stream so the block backs up into req
   initial begin
      wait (words_sent >= HOLD_AT_WORD);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   task automatic send_word(sbs_op_type op, logic [RTT_W-1:0] rtt);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= rtt;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.add_word(op, rtt);
      words_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(logic write, sbs_reg_type r, logic [31:0] v,
                             output logic [31:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'({r, 2'b00});
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_register(sbs_reg_type r, logic [31:0] v);
      logic [31:0] rd;
      csr_access(1'b1, r, v, rd);
      sb.write_reg(r, v);
      csr_access(1'b0, r, '0, rd);
      if (rd !== sb.reg_value(r))
         sb.report($sformatf("register %s reads %0h, want %0h", r.name(), rd,
                             sb.reg_value(r)));
   endtask

   task automatic program_search(logic [31:0] base_v, logic [31:0] upper_v,
                                 logic [31:0] lower_v, logic [31:0] len_v);
      set_register(REG_BASELINE, base_v);
      set_register(REG_THR_UPPER, upper_v);
      set_register(REG_THR_LOWER, lower_v);
      set_register(REG_PATH_LEN, len_v);
   endtask

   function automatic logic [RTT_W-1:0] pick_rtt(int unsigned b);
      int unsigned k, lo3, hi5;
      k   = $urandom_range(0, 19);
      lo3 = (3 * b > 65535) ? 65535 : 3 * b;
      hi5 = (5 * b > 65535) ? 65535 : 5 * b;
      if (k < 7) return RTT_W'($urandom_range(0, b));
      if (k < 14) return RTT_W'($urandom_range(lo3, hi5));
      if (k < 17) return RTT_W'($urandom);
      if (k < 19) return 16'hFFFF - RTT_W'($urandom_range(0, 255));
      return (2 * b > 65535) ? 16'hFFFF : RTT_W'(2 * b);
   endfunction

   task automatic run_phase(int count);
      int  sent, steps;
      bit  first;
      sent  = 0;
      first = 1'b1;
      while (sent < count) begin
         if ($urandom_range(0, first ? 1 : 9) != 0) begin
            send_word(OP_START, RTT_W'($urandom));
            sent++;
         end
         first = 1'b0;
         steps = 0;
         while (!sb.done && steps < MAX_STEPS && sent < count) begin
            send_word(OP_SAMPLE, pick_rtt(sb.eff_baseline()));
            sent++;
            steps++;
         end
         repeat ($urandom_range(0, 2)) begin
            if (sent < count) begin
               send_word(OP_SAMPLE, RTT_W'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: empty path, sample before any start
      send_word(OP_SAMPLE, 16'd0);
      send_word(OP_SAMPLE, 16'hFFFF);
      send_word(OP_START, 16'hFFFF);
      send_word(OP_SAMPLE, 16'd160);
      drain_results();

      program_search(32'd40, 32'd2944, -32'sd2944, 32'd16);
      send_word(OP_START, 16'd0);
      send_word(OP_SAMPLE, 16'd160);
      send_word(OP_SAMPLE, 16'd0);
      send_word(OP_SAMPLE, 16'd160);
      send_word(OP_SAMPLE, 16'd0);
      send_word(OP_SAMPLE, 16'hFFFF);
      send_word(OP_START, 16'd0);
      send_word(OP_SAMPLE, 16'd80);
      send_word(OP_SAMPLE, 16'd79);
      send_word(OP_SAMPLE, 16'd81);
      send_word(OP_SAMPLE, 16'hFFFF);
      drain_results();

      // shrink the path under a running search
      program_search(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd4);
      send_word(OP_SAMPLE, 16'd0);
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_search(32'd0, 32'd1, 32'hFFFF_FFFF, 32'd16);
            1: program_search(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd31);
            2: program_search(32'd65535, 32'd2944, -32'sd2944, 32'd1);
            3: program_search(32'd40, 32'd2944, -32'sd2944, 32'd2);
            4: program_search($urandom, $urandom | 32'h1, $urandom | 32'h8000_0000, $urandom);
            5: program_search(32'd40, 32'd6000, -32'sd6000, 32'd0);
            default:
               program_search(($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 300),
                              $urandom_range(1, 12000), -$urandom_range(1, 12000),
                              $urandom_range(0, 31));
         endcase
         run_phase(PHASE_WORDS);
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
